### rtl/pwg_pkg.sv
// Shared constants, configuration record and sine table for the waveform generator.
package pwg_pkg;

  // Table size and phase resolution
  localparam int SINE_TABLE_ENTRIES  = 1024;
  localparam int PHASE_FRACTION_BITS = 16;
  localparam int PHASE_BITS_MAX      = 24;

  // Derived widths
  localparam int ADDR_W  = $clog2(SINE_TABLE_ENTRIES + 1);
  localparam int QUAD_W  = PHASE_FRACTION_BITS - 2;
  localparam int TRI_W   = PHASE_FRACTION_BITS + 4;

  // Shape levels, Q1.15
  localparam logic signed [15:0] SHAPE_MAX   = 16'sh7FFF;
  localparam logic signed [15:0] SHAPE_MIN   = 16'sh8000;
  localparam logic [14:0]        PULSE_LEVEL = 15'd32441;

  // Waveform codes
  localparam logic [2:0] WAVE_SINE        = 3'd0;
  localparam logic [2:0] WAVE_SQUARE      = 3'd1;
  localparam logic [2:0] WAVE_TRIANGLE    = 3'd2;
  localparam logic [2:0] WAVE_SAWTOOTH    = 3'd3;
  localparam logic [2:0] WAVE_PULSE       = 3'd4;
  localparam logic [2:0] WAVE_PULSE_TRAIN = 3'd5;

  // Register indexes
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;
  localparam logic [CFG_INDEX_W-1:0] REG_WAVEFORM      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FREQUENCY     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PHASE_OFFSET  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_AMPLITUDE     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_OUTPUT_OFFSET = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_INVERT        = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_TRIGGER_LEVEL = 3'd6;

  // Configuration registers as seen by the datapath
  typedef struct packed {
    logic [2:0]         waveform;
    logic [31:0]        frequency;
    logic [15:0]        phase_offset;
    logic signed [15:0] amplitude;
    logic signed [31:0] output_offset;
    logic               invert;
    logic signed [15:0] trigger_level;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    waveform:      WAVE_SINE,
    frequency:     32'd65536,
    phase_offset:  16'd0,
    amplitude:     16'sd4096,
    output_offset: 32'sd0,
    invert:        1'b0,
    trigger_level: 16'sd0
  };

  // Quarter-wave sine table, entries 0 through SINE_TABLE_ENTRIES
  typedef logic [SINE_TABLE_ENTRIES:0][14:0] sine_tab_t;

  localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;
  localparam longint unsigned Q30_HALF    = 64'd536870912;

  // Taylor series to the x^13 term in Q2.30, rounded to Q1.15
  function automatic sine_tab_t build_sine_table();
    sine_tab_t       tab;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned sum;
    longint unsigned v;
    longint unsigned t;
    tab = '0;
    for (int k = 0; k <= SINE_TABLE_ENTRIES; k++) begin
      x    = (PI_HALF_Q30 * longint'(k)) / SINE_TABLE_ENTRIES;
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      for (int n = 1; n <= 6; n++) begin
        t = (term * x2) >> 30;
        case (n)
          1:       term = t / 6;
          2:       term = t / 20;
          3:       term = t / 42;
          4:       term = t / 72;
          5:       term = t / 110;
          default: term = t / 156;
        endcase
        if ((n % 2) == 1) begin
          sum = (sum >= term) ? sum - term : 64'd0;
        end else begin
          sum = sum + term;
        end
      end
      v = (sum * 64'd32768 + Q30_HALF) >> 30;
      if (v > 64'd32767) v = 64'd32767;
      tab[k] = v[14:0];
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TABLE = build_sine_table();

  // Phase-scaled value to Q1.15, floored and saturated
  function automatic logic signed [15:0] to_q15(input logic signed [TRI_W-1:0] v);
    logic signed [TRI_W+14:0] sc;
    sc = $signed({v, 15'b0}) >>> PHASE_FRACTION_BITS;
    if (sc > SHAPE_MAX) return SHAPE_MAX;
    if (sc < SHAPE_MIN) return SHAPE_MIN;
    return sc[15:0];
  endfunction

endpackage

### rtl/pwg_if.sv
// Stream interfaces for sample times and generated samples.
interface pwg_time_if;
  logic        valid;
  logic        ready;
  logic [31:0] time_seconds;

  modport source (output valid, output time_seconds, input ready);
  modport sink   (input valid, input time_seconds, output ready);
endinterface

interface pwg_sample_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sample_value;

  modport source (output valid, output sample_value, input ready);
  modport sink   (input valid, input sample_value, output ready);
endinterface

### rtl/pwg_cfg.sv
// Configuration register file: write decode and reset values.
module pwg_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [pwg_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [pwg_pkg::CFG_DATA_W-1:0]     cfg_data,
  output pwg_pkg::cfg_t                      cfg
);
  import pwg_pkg::*;

  // Load the addressed register; drop writes past the last index
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_WAVEFORM:      cfg.waveform      <= cfg_data[2:0];
        REG_FREQUENCY:     cfg.frequency     <= cfg_data[31:0];
        REG_PHASE_OFFSET:  cfg.phase_offset  <= cfg_data[15:0];
        REG_AMPLITUDE:     cfg.amplitude     <= $signed(cfg_data[15:0]);
        REG_OUTPUT_OFFSET: cfg.output_offset <= $signed(cfg_data[31:0]);
        REG_INVERT:        cfg.invert        <= cfg_data[0];
        REG_TRIGGER_LEVEL: cfg.trigger_level <= $signed(cfg_data[15:0]);
        default: begin
        end
      endcase
    end
  end

endmodule

### rtl/periodic_waveform_generator.sv
// Top level: seven-stage pipelined waveform generator from sample times.
//
// Usage:
//   times   - input stream, one beat per sample time (unsigned Q16.16 seconds).
//   samples - output stream, one beat per input beat, signed Q16.16, same order.
//   cfg_*   - register write port (index, data); write only while no beat is
//             in flight. Registers are waveform, frequency, phase_offset,
//             amplitude, output_offset, invert and trigger_level.
// Throughput is one beat per cycle unless the receiver stalls; the stages are
// the 32x32 phase multiply, the phase add, the table address and ramp shapes,
// the sine table read, the shape select and invert, the amplitude multiply,
// and the offset add with saturation.
// Reset clears all stage valid bits and loads the register reset values
// (sine, 1 Hz, unity gain, no offset). No table initialization is needed.
// When the receiver stalls, full stages hold and bubbles close up; input
// ready drops only once every stage holds a beat.
module periodic_waveform_generator (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [pwg_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [pwg_pkg::CFG_DATA_W-1:0]   cfg_data,
  pwg_time_if.sink                         times,
  pwg_sample_if.source                     samples
);
  import pwg_pkg::*;

  localparam int PFB = PHASE_FRACTION_BITS;
  localparam logic [ADDR_W-1:0] ENTRIES_A = ADDR_W'(SINE_TABLE_ENTRIES);
  localparam logic signed [TRI_W-1:0] ONE_T = TRI_W'(2 ** PFB);

  cfg_t cfg;

  pwg_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Stage valid bits and enables
  logic [7:1] vld;
  logic [7:1] en;
  logic [6:0] vin;

  assign vin = {vld[6:1], times.valid};

  // Advance a stage when it is empty or the next one advances
  always_comb begin
    en[7] = !vld[7] || samples.ready;
    for (int i = 6; i >= 1; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign times.ready = en[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int i = 1; i <= 7; i++) begin
        if (en[i]) vld[i] <= vin[i-1];
      end
    end
  end

  // Stage payload registers
  logic [31:0]              prod1;
  logic [PFB-1:0]           pos2;
  logic [ADDR_W-1:0]        addr3;
  logic                     quadhi3;
  logic signed [15:0]       tri3;
  logic signed [15:0]       saw3;
  logic [14:0]              raw4;
  logic                     quadhi4;
  logic signed [15:0]       tri4;
  logic signed [15:0]       saw4;
  logic signed [15:0]       shape5;
  logic signed [31:0]       mul6;
  logic signed [31:0]       sample7;

  // Phase add
  logic [PHASE_BITS_MAX+15:0] ph_wide;
  logic [PFB-1:0]             ph_c;
  logic [PFB-1:0]             pos_c;

  assign ph_wide = {cfg.phase_offset, PHASE_BITS_MAX'(0)};
  assign ph_c    = ph_wide[PHASE_BITS_MAX+15 -: PFB];
  assign pos_c   = prod1[31 -: PFB] + ph_c;

  // Table address and ramp shapes
  logic [1:0]              quad_c;
  logic [QUAD_W-1:0]       rest_c;
  logic [QUAD_W+ADDR_W-1:0] kprod_c;
  logic [ADDR_W-1:0]       k_c;
  logic [ADDR_W-1:0]       addr_c;
  logic signed [TRI_W-1:0] p4_c;
  logic signed [TRI_W-1:0] p2_c;
  logic signed [TRI_W-1:0] tri_t;
  logic signed [TRI_W-1:0] saw_t;

  assign quad_c  = pos2[PFB-1 -: 2];
  assign rest_c  = pos2[QUAD_W-1:0];
  assign kprod_c = (QUAD_W+ADDR_W)'(rest_c) * (QUAD_W+ADDR_W)'(SINE_TABLE_ENTRIES);
  assign k_c     = kprod_c[QUAD_W +: ADDR_W];
  assign addr_c  = quad_c[0] ? ENTRIES_A - k_c : k_c;
  assign p4_c    = TRI_W'({pos2, 2'b00});
  assign p2_c    = TRI_W'({pos2, 1'b0});

  always_comb begin
    case (quad_c)
      2'd0:    tri_t = p4_c;
      2'd3:    tri_t = p4_c - (ONE_T <<< 2);
      default: tri_t = (ONE_T <<< 1) - p4_c;
    endcase
    saw_t = pos2[PFB-1] ? p2_c - (ONE_T <<< 1) : p2_c;
  end

  // Shape select and invert
  logic signed [15:0] sine_c;
  logic signed [15:0] shape_c;

  always_comb begin
    sine_c = quadhi4 ? -$signed({1'b0, raw4}) : $signed({1'b0, raw4});
    case (cfg.waveform)
      WAVE_SINE:        shape_c = sine_c;
      WAVE_SQUARE:      shape_c = (raw4 == '0) ? 16'sd0 : (quadhi4 ? SHAPE_MIN : SHAPE_MAX);
      WAVE_TRIANGLE:    shape_c = tri4;
      WAVE_SAWTOOTH:    shape_c = saw4;
      WAVE_PULSE:       shape_c = (raw4 >= PULSE_LEVEL) ? SHAPE_MAX : 16'sd0;
      WAVE_PULSE_TRAIN: shape_c = ($signed(tri4) > $signed(cfg.trigger_level)) ?
                                  SHAPE_MAX : 16'sd0;
      default:          shape_c = 16'sd0;
    endcase
    if (cfg.invert) begin
      shape_c = (shape_c == SHAPE_MIN) ? SHAPE_MAX : -shape_c;
    end
  end

  // Amplitude multiply
  logic signed [31:0] mul_c;
  assign mul_c = 32'(shape5) * 32'(cfg.amplitude);

  // Floor to Q16.16, add offset, saturate
  logic signed [32:0] sum_c;
  logic signed [31:0] sat_c;

  assign sum_c = 33'(mul6 >>> 11) + 33'(cfg.output_offset);
  assign sat_c = (sum_c[32] != sum_c[31]) ?
                 (sum_c[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : sum_c[31:0];

  // Advance payload with its valid bit
  always_ff @(posedge clk) begin
    if (en[1]) prod1 <= cfg.frequency * times.time_seconds;
    if (en[2]) pos2  <= pos_c;
    if (en[3]) begin
      addr3   <= addr_c;
      quadhi3 <= quad_c[1];
      tri3    <= to_q15(tri_t);
      saw3    <= to_q15(saw_t);
    end
    if (en[4]) begin
      raw4    <= SINE_TABLE[addr3];
      quadhi4 <= quadhi3;
      tri4    <= tri3;
      saw4    <= saw3;
    end
    if (en[5]) shape5  <= shape_c;
    if (en[6]) mul6    <= mul_c;
    if (en[7]) sample7 <= sat_c;
  end

  assign samples.valid        = vld[7];
  assign samples.sample_value = sample7;

  // A full pipeline with a stalled receiver takes no new beat
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    (&vld && !samples.ready) |-> !times.ready)
    else $error("input taken while pipeline is full and stalled");

  // An accepted beat occupies the first stage next cycle
  a_enter: assert property (@(posedge clk) disable iff (rst)
    (times.valid && times.ready) |=> vld[1])
    else $error("accepted beat did not enter the pipeline");

  // Table address stays within the quarter-wave table
  a_addr_range: assert property (@(posedge clk) disable iff (rst)
    vld[3] |-> (addr3 <= ENTRIES_A))
    else $error("sine table address out of range");

  // Pulse shapes are two-level
  a_pulse_levels: assert property (@(posedge clk) disable iff (rst)
    (vld[5] && (cfg.waveform == WAVE_PULSE || cfg.waveform == WAVE_PULSE_TRAIN)) |->
    (shape5 == 16'sd0 || shape5 == SHAPE_MAX || shape5 == -SHAPE_MAX))
    else $error("pulse shape not at a pulse level");

endmodule
